>>> rtl/deq_pkg.sv
// deq_pkg: shared types and codes for the deadline event queue.
// Used by the interface file and by every rtl module.
package deq_pkg;
	localparam int TIME_W = 48;
	localparam int MSG_W = 32;
	localparam int OWN_W = 4;
	localparam int SEQ_W = 16;
	localparam int LIM_W = 9;
	localparam int CNT_W = 6;

	typedef enum logic [1:0] {
		FUNC_TICK = 2'd0,
		FUNC_INSERT = 2'd1,
		FUNC_CANCEL = 2'd2,
		FUNC_NOP = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_OWNER_LIMIT = 2'd1,
		ST_POOL_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0] func;
		logic [TIME_W-1:0] current_time;
		logic [OWN_W-1:0] owner_id;
		logic [TIME_W-1:0] trigger_time;
		logic [MSG_W-1:0] message_code;
	} cmd_t;

	typedef struct packed {
		logic record_kind;
		logic [OWN_W-1:0] fired_owner;
		logic [MSG_W-1:0] fired_message;
		logic [TIME_W-1:0] fired_time;
		logic [1:0] status_code;
		logic [CNT_W-1:0] removed_count;
		logic deadline_valid;
		logic [TIME_W-1:0] next_due;
		logic last_record;
	} rec_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SCAN,
		BK_EMIT,
		BK_INS,
		BK_FINAL,
		BK_STATUS
	} bk_state_t;
endpackage

>>> rtl/deq_if.sv
// deq_if: valid/ready channels for commands, records and the limit register.
// Depends on deq_pkg.
interface deq_cmd_if;
	logic valid;
	logic ready;
	logic [1:0] func;
	logic [deq_pkg::TIME_W-1:0] current_time;
	logic [deq_pkg::OWN_W-1:0] owner_id;
	logic [deq_pkg::TIME_W-1:0] trigger_time;
	logic [deq_pkg::MSG_W-1:0] message_code;
	modport source(output valid, func, current_time, owner_id, trigger_time, message_code,
		input ready);
	modport sink(input valid, func, current_time, owner_id, trigger_time, message_code,
		output ready);
endinterface

interface deq_rec_if;
	logic valid;
	logic ready;
	logic record_kind;
	logic [deq_pkg::OWN_W-1:0] fired_owner;
	logic [deq_pkg::MSG_W-1:0] fired_message;
	logic [deq_pkg::TIME_W-1:0] fired_time;
	logic [1:0] status_code;
	logic [deq_pkg::CNT_W-1:0] removed_count;
	logic deadline_valid;
	logic [deq_pkg::TIME_W-1:0] next_due;
	logic last_record;
	modport source(output valid, record_kind, fired_owner, fired_message, fired_time,
		status_code, removed_count, deadline_valid, next_due, last_record, input ready);
	modport sink(input valid, record_kind, fired_owner, fired_message, fired_time,
		status_code, removed_count, deadline_valid, next_due, last_record, output ready);
endinterface

interface deq_cfg_if;
	logic valid;
	logic ready;
	logic [deq_pkg::LIM_W-1:0] data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

>>> rtl/deq_front.sv
// deq_front: accepts commands into a two-entry queue for the back end.
// Depends on deq_pkg and deq_if.
module deq_front (
	input logic clk,
	input logic arst_n,
	deq_cmd_if.sink cmd,
	output logic q_valid,
	input logic q_pop,
	output deq_pkg::cmd_t q_head
);
	deq_pkg::cmd_t mem_q [2];
	logic [1:0] rd_q;
	logic [1:0] wr_q;
	logic push;
	deq_pkg::cmd_t incoming;

	assign incoming = '{func: cmd.func, current_time: cmd.current_time,
		owner_id: cmd.owner_id, trigger_time: cmd.trigger_time,
		message_code: cmd.message_code};
	assign cmd.ready = (wr_q - rd_q) != 2'd2;
	assign push = cmd.valid && cmd.ready;
	assign q_valid = wr_q != rd_q;
	assign q_head = mem_q[rd_q[0]];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q[0]] <= incoming;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0;
			wr_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 2'd1;
			if (q_pop) rd_q <= rd_q + 2'd1;
		end
	end
endmodule

>>> rtl/deq_back.sv
// deq_back: slot pool and sequencer; one slot is examined per scan cycle.
// Depends on deq_pkg.
module deq_back #(
	parameter int POOL_SLOTS = 32,
	parameter int OWNER_COUNT = 16
) (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	output logic q_pop,
	input deq_pkg::cmd_t q_head,
	input logic [deq_pkg::LIM_W-1:0] limit,
	output logic rec_valid,
	input logic rec_ready,
	output deq_pkg::rec_t rec
);
	localparam int SW = $clog2(POOL_SLOTS);
	localparam int OW = (OWNER_COUNT > 1) ? $clog2(OWNER_COUNT) : 1;

	logic [POOL_SLOTS-1:0] valid_q;
	logic [deq_pkg::TIME_W-1:0] time_q [POOL_SLOTS];
	logic [deq_pkg::OWN_W-1:0] owner_q [POOL_SLOTS];
	logic [deq_pkg::MSG_W-1:0] msg_q [POOL_SLOTS];
	logic [deq_pkg::SEQ_W-1:0] seq_q [POOL_SLOTS];
	logic [deq_pkg::LIM_W-1:0] pend_q [OWNER_COUNT];
	logic [deq_pkg::SEQ_W-1:0] ctr_q;

	deq_pkg::bk_state_t state_q, state_d;
	logic [SW-1:0] idx_q;
	logic [deq_pkg::CNT_W-1:0] removed_q;
	logic [1:0] status_q;
	logic found_q;
	logic [SW-1:0] best_q;
	logic [deq_pkg::TIME_W-1:0] best_time_q;
	logic [deq_pkg::SEQ_W-1:0] best_age_q;
	logic free_found_q;
	logic [SW-1:0] free_q;
	logic final_pass_q;

	logic [deq_pkg::TIME_W-1:0] lim_time;
	logic [deq_pkg::SEQ_W-1:0] cur_age;
	logic cand, better, last_idx, own_ok;
	logic [OW-1:0] own_idx;
	logic [deq_pkg::OWN_W-1:0] cur_own;
	logic [deq_pkg::OWN_W-1:0] cmd_own;

	assign cmd_own = q_head.owner_id;
	assign own_idx = OW'(cmd_own);
	assign own_ok = 32'(cmd_own) < OWNER_COUNT;
	assign lim_time = final_pass_q ? '1 : q_head.current_time;
	assign cur_age = ctr_q - seq_q[idx_q];
	assign cand = valid_q[idx_q] && time_q[idx_q] <= lim_time;
	assign better = !found_q || time_q[idx_q] < best_time_q ||
		(time_q[idx_q] == best_time_q && cur_age > best_age_q);
	assign last_idx = 32'(idx_q) == POOL_SLOTS - 1;
	assign cur_own = owner_q[best_q];

	always_comb begin
		state_d = state_q;
		q_pop = 1'b0;
		rec_valid = 1'b0;
		rec = '0;
		unique case (state_q)
			deq_pkg::BK_IDLE: if (q_valid) state_d = deq_pkg::BK_SCAN;
			deq_pkg::BK_SCAN: if (last_idx) begin
				if (final_pass_q) state_d = deq_pkg::BK_STATUS;
				else if (q_head.func == deq_pkg::FUNC_TICK)
					state_d = (found_q || cand) ? deq_pkg::BK_EMIT : deq_pkg::BK_FINAL;
				else if (q_head.func == deq_pkg::FUNC_INSERT) state_d = deq_pkg::BK_INS;
				else state_d = deq_pkg::BK_FINAL;
			end
			deq_pkg::BK_EMIT: begin
				rec_valid = 1'b1;
				rec.fired_owner = cur_own;
				rec.fired_message = msg_q[best_q];
				rec.fired_time = time_q[best_q];
				if (rec_ready) state_d = deq_pkg::BK_SCAN;
			end
			deq_pkg::BK_INS: state_d = deq_pkg::BK_FINAL;
			deq_pkg::BK_FINAL: state_d = deq_pkg::BK_SCAN;
			deq_pkg::BK_STATUS: begin
				rec_valid = 1'b1;
				rec.record_kind = 1'b1;
				rec.status_code = status_q;
				rec.removed_count = removed_q;
				rec.deadline_valid = found_q;
				rec.next_due = found_q ? best_time_q : '0;
				rec.last_record = 1'b1;
				if (rec_ready) begin
					q_pop = 1'b1;
					state_d = deq_pkg::BK_IDLE;
				end
			end
			default: state_d = deq_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= deq_pkg::BK_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ctr_q <= '0;
			for (int i = 0; i < OWNER_COUNT; i++) pend_q[i] <= '0;
			idx_q <= '0;
			removed_q <= '0;
			status_q <= '0;
			found_q <= 1'b0;
			free_found_q <= 1'b0;
			final_pass_q <= 1'b0;
		end else begin
			unique case (state_q)
				deq_pkg::BK_IDLE: begin
					idx_q <= '0;
					removed_q <= '0;
					status_q <= deq_pkg::ST_DONE;
					found_q <= 1'b0;
					free_found_q <= 1'b0;
					final_pass_q <= 1'b0;
				end
				deq_pkg::BK_SCAN: begin
					// cancel drops matching slots during its one pass
					if (!final_pass_q && q_head.func == deq_pkg::FUNC_CANCEL &&
							valid_q[idx_q] && owner_q[idx_q] == cmd_own) begin
						valid_q[idx_q] <= 1'b0;
						removed_q <= removed_q + deq_pkg::CNT_W'(1);
						if (own_ok && pend_q[own_idx] != '0)
							pend_q[own_idx] <= pend_q[own_idx] - deq_pkg::LIM_W'(1);
					end else if (cand && better) begin
						found_q <= 1'b1;
						best_q <= idx_q;
						best_time_q <= time_q[idx_q];
						best_age_q <= cur_age;
					end
					if (!valid_q[idx_q] && !free_found_q) begin
						free_found_q <= 1'b1;
						free_q <= idx_q;
					end
					idx_q <= last_idx ? '0 : idx_q + SW'(1);
				end
				deq_pkg::BK_EMIT: if (rec_ready) begin
					valid_q[best_q] <= 1'b0;
					if (32'(cur_own) < OWNER_COUNT && pend_q[OW'(cur_own)] != '0)
						pend_q[OW'(cur_own)] <= pend_q[OW'(cur_own)] - deq_pkg::LIM_W'(1);
					found_q <= 1'b0;
				end
				deq_pkg::BK_INS: begin
					if (!own_ok || pend_q[own_idx] >= limit)
						status_q <= deq_pkg::ST_OWNER_LIMIT;
					else if (!free_found_q) status_q <= deq_pkg::ST_POOL_FULL;
					else begin
						valid_q[free_q] <= 1'b1;
						time_q[free_q] <= q_head.trigger_time;
						owner_q[free_q] <= cmd_own;
						msg_q[free_q] <= q_head.message_code;
						seq_q[free_q] <= ctr_q;
						ctr_q <= ctr_q + deq_pkg::SEQ_W'(1);
						pend_q[own_idx] <= pend_q[own_idx] + deq_pkg::LIM_W'(1);
					end
				end
				deq_pkg::BK_FINAL: begin
					final_pass_q <= 1'b1;
					found_q <= 1'b0;
					idx_q <= '0;
				end
				deq_pkg::BK_STATUS: ;
				default: ;
			endcase
		end
	end
endmodule

>>> rtl/deadline_event_queue.sv
// Top level of the deadline event queue; depends on deq_pkg, deq_if, deq_front, deq_back.
// Each item walks the slot pool one slot per cycle: a command takes one pass over
// the pool plus a final pass to find the next deadline, and a tick adds one more
// pass and one record per expired event; an insert adds an insert step, and the
// record sink can stall each record. A two-entry queue lets new items arrive while the
// back end works; the limit register resets to 256.
module deadline_event_queue #(
	parameter int POOL_SLOTS = 32,
	parameter int OWNER_COUNT = 16
) (
	input logic clk,
	input logic arst_n,
	deq_cmd_if.sink cmd,
	deq_cfg_if.sink cfg,
	deq_rec_if.source rec
);
	logic q_valid, q_pop;
	deq_pkg::cmd_t q_head;
	deq_pkg::rec_t r;
	logic [deq_pkg::LIM_W-1:0] limit_q;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) limit_q <= deq_pkg::LIM_W'(256);
		else if (cfg.valid) limit_q <= cfg.data;
	end

	deq_front u_front (.clk, .arst_n, .cmd, .q_valid, .q_pop, .q_head);

	deq_back #(.POOL_SLOTS(POOL_SLOTS), .OWNER_COUNT(OWNER_COUNT)) u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_head, .limit(limit_q),
		.rec_valid(rec.valid), .rec_ready(rec.ready), .rec(r));

	assign rec.record_kind = r.record_kind;
	assign rec.fired_owner = r.fired_owner;
	assign rec.fired_message = r.fired_message;
	assign rec.fired_time = r.fired_time;
	assign rec.status_code = r.status_code;
	assign rec.removed_count = r.removed_count;
	assign rec.deadline_valid = r.deadline_valid;
	assign rec.next_due = r.next_due;
	assign rec.last_record = r.last_record;
endmodule

>>> tb/tb_deadline_event_queue.sv
// tb_deadline_event_queue: self-checking testbench for the deadline event queue.
// Depends on deq_pkg, the channel interfaces in deq_if and the rtl top level.
// A scoreboard class predicts the expired-event and status records of each accepted item.

class deq_scoreboard;
	bit [8:0] owner_limit;
	bit slot_used[32];
	bit [47:0] slot_trigger[32];
	bit [3:0] slot_owner_id[32];
	bit [31:0] slot_msg[32];
	bit [15:0] slot_seq[32];
	bit [8:0] owner_count[16];
	bit [15:0] insert_seq;
	deq_pkg::rec_t records_due[$];
	int mismatches;
	int records_seen;

	function new();
		owner_limit = 9'd256;
		insert_seq = '0;
		mismatches = 0;
		records_seen = 0;
		foreach (slot_used[i]) slot_used[i] = 1'b0;
		foreach (owner_count[i]) owner_count[i] = '0;
	endfunction

	// Earliest pending slot due at or before horizon; older insert wins a tie.
	function int earliest_due(bit [47:0] horizon);
		int best;
		bit [15:0] age_s;
		bit [15:0] age_b;
		best = -1;
		for (int s = 0; s < 32; s++) begin
			if (!slot_used[s] || slot_trigger[s] > horizon)
				continue;
			if (best < 0) begin
				best = s;
				continue;
			end
			age_s = insert_seq - slot_seq[s];
			age_b = insert_seq - slot_seq[best];
			if (slot_trigger[s] < slot_trigger[best] ||
				(slot_trigger[s] == slot_trigger[best] && age_s > age_b))
				best = s;
		end
		return best;
	endfunction

	function void release_slot(int s);
		slot_used[s] = 1'b0;
		if (owner_count[slot_owner_id[s]] != 0)
			owner_count[slot_owner_id[s]]--;
	endfunction

	function void note_command(deq_pkg::cmd_t c);
		deq_pkg::rec_t r;
		deq_pkg::func_t f;
		int s;
		int first_free;
		bit [1:0] status;
		bit [5:0] removed;
		status = deq_pkg::ST_DONE;
		removed = '0;
		f = deq_pkg::func_t'(c.func);
		case (f)
			deq_pkg::FUNC_TICK: begin
				forever begin
					s = earliest_due(c.current_time);
					if (s < 0)
						break;
					r = '0;
					r.fired_owner = slot_owner_id[s];
					r.fired_message = slot_msg[s];
					r.fired_time = slot_trigger[s];
					records_due.push_back(r);
					release_slot(s);
				end
			end
			deq_pkg::FUNC_INSERT: begin
				if (owner_count[c.owner_id] >= owner_limit) begin
					status = deq_pkg::ST_OWNER_LIMIT;
				end else begin
					first_free = -1;
					for (int i = 0; i < 32; i++)
						if (!slot_used[i] && first_free < 0)
							first_free = i;
					if (first_free < 0) begin
						status = deq_pkg::ST_POOL_FULL;
					end else begin
						slot_used[first_free] = 1'b1;
						slot_trigger[first_free] = c.trigger_time;
						slot_owner_id[first_free] = c.owner_id;
						slot_msg[first_free] = c.message_code;
						slot_seq[first_free] = insert_seq;
						insert_seq++;
						owner_count[c.owner_id]++;
					end
				end
			end
			deq_pkg::FUNC_CANCEL: begin
				for (int i = 0; i < 32; i++)
					if (slot_used[i] && slot_owner_id[i] == c.owner_id) begin
						release_slot(i);
						removed++;
					end
			end
			default: ;
		endcase
		r = '0;
		r.record_kind = 1'b1;
		r.status_code = status;
		r.removed_count = removed;
		s = earliest_due('1);
		if (s >= 0) begin
			r.deadline_valid = 1'b1;
			r.next_due = slot_trigger[s];
		end
		r.last_record = 1'b1;
		records_due.push_back(r);
	endfunction

	function void check_record(deq_pkg::rec_t got);
		deq_pkg::rec_t want;
		records_seen++;
		if (records_due.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("ERROR: record with none expected: %p", got);
			return;
		end
		want = records_due.pop_front();
		if (got.record_kind !== want.record_kind || got.fired_owner !== want.fired_owner ||
			got.fired_message !== want.fired_message || got.fired_time !== want.fired_time ||
			got.status_code !== want.status_code || got.removed_count !== want.removed_count ||
			got.deadline_valid !== want.deadline_valid ||
			got.next_due !== want.next_due || got.last_record !== want.last_record) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("ERROR: record %0d mismatch", records_seen);
				$display("  expected %p", want);
				$display("  actual   %p", got);
			end
		end
	endfunction
endclass

module tb_deadline_event_queue;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 2000000;

	logic clk;
	logic arst_n;
	int cycles;
	int items_sent;
	bit calm;
	bit [47:0] now_us;
	deq_scoreboard board;

	deq_cmd_if cmd_ch();
	deq_cfg_if cfg_ch();
	deq_rec_if rec_ch();

	deadline_event_queue dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.cfg(cfg_ch),
		.rec(rec_ch)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("simulation failed");
			$finish;
		end
	end

	function automatic int draw_gap();
		return calm ? 0 : $urandom_range(0, 7);
	endfunction

	function automatic deq_pkg::cmd_t make_cmd(deq_pkg::func_t f, bit [47:0] t_now,
		bit [3:0] own, bit [47:0] trig, bit [31:0] msg);
		deq_pkg::cmd_t c;
		c.func = f;
		c.current_time = t_now;
		c.owner_id = own;
		c.trigger_time = trig;
		c.message_code = msg;
		return c;
	endfunction

	task automatic send_cmd(deq_pkg::cmd_t c);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.func <= c.func;
		cmd_ch.current_time <= c.current_time;
		cmd_ch.owner_id <= c.owner_id;
		cmd_ch.trigger_time <= c.trigger_time;
		cmd_ch.message_code <= c.message_code;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		board.note_command(c);
		items_sent++;
	endtask

	task automatic hold_cmd_idle();
		cmd_ch.valid <= 1'b0;
	endtask

	// Drain all outstanding records, then write the owner limit.
	task automatic write_limit(bit [8:0] value);
		hold_cmd_idle();
		@(posedge clk);
		while (board.records_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		board.owner_limit = value;
	endtask

	function automatic bit [47:0] wide_time();
		return {16'($urandom_range(0, 65535)), $urandom};
	endfunction

	function automatic deq_pkg::cmd_t random_cmd(int owner_span);
		int pick;
		bit [47:0] trig;
		pick = $urandom_range(0, 99);
		trig = now_us + $urandom_range(0, 300);
		if ($urandom_range(0, 15) == 0)
			trig = wide_time();
		else if ($urandom_range(0, 5) == 0)
			trig = now_us + 48'd50;
		if (pick < 50)
			return make_cmd(deq_pkg::FUNC_INSERT, wide_time(),
				4'($urandom_range(0, owner_span)), trig, $urandom);
		if (pick < 80) begin
			now_us = now_us + $urandom_range(0, 200);
			if ($urandom_range(0, 20) == 0)
				return make_cmd(deq_pkg::FUNC_TICK, '1, 4'($urandom), wide_time(),
					$urandom);
			return make_cmd(deq_pkg::FUNC_TICK, now_us, 4'($urandom), wide_time(),
				$urandom);
		end
		if (pick < 95)
			return make_cmd(deq_pkg::FUNC_CANCEL, wide_time(),
				4'($urandom_range(0, owner_span)), wide_time(), $urandom);
		return make_cmd(deq_pkg::FUNC_NOP, wide_time(), 4'($urandom), wide_time(),
			$urandom);
	endfunction

	task automatic random_phase(int n, int owner_span);
		for (int i = 0; i < n; i++) begin
			if (i % 20 == 0)
				calm = ($urandom_range(0, 3) == 0);
			send_cmd(random_cmd(owner_span));
		end
		calm = 1'b0;
	endtask

	// Record sink: random stall before each record, held ready when no stall.
	initial begin
		deq_pkg::rec_t got;
		int stall;
		rec_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = draw_gap();
			if (stall > 0) begin
				rec_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rec_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rec_ch.valid) @(posedge clk);
			got.record_kind = rec_ch.record_kind;
			got.fired_owner = rec_ch.fired_owner;
			got.fired_message = rec_ch.fired_message;
			got.fired_time = rec_ch.fired_time;
			got.status_code = rec_ch.status_code;
			got.removed_count = rec_ch.removed_count;
			got.deadline_valid = rec_ch.deadline_valid;
			got.next_due = rec_ch.next_due;
			got.last_record = rec_ch.last_record;
			board.check_record(got);
		end
	end

	initial begin
		board = new();
		cycles = 0;
		items_sent = 0;
		calm = 1'b0;
		now_us = 48'd1000;
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.func = '0;
		cmd_ch.current_time = '0;
		cmd_ch.owner_id = '0;
		cmd_ch.trigger_time = '0;
		cmd_ch.message_code = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty pool, unused func, field extremes, equal times, cancels
		send_cmd(make_cmd(deq_pkg::FUNC_TICK, '0, '0, '0, '0));
		send_cmd(make_cmd(deq_pkg::FUNC_NOP, '1, '1, '1, '1));
		send_cmd(make_cmd(deq_pkg::FUNC_INSERT, '1, 4'd0, '0, '0));
		send_cmd(make_cmd(deq_pkg::FUNC_INSERT, '0, 4'd15, '1, '1));
		send_cmd(make_cmd(deq_pkg::FUNC_INSERT, '0, 4'd1, 48'd100, 32'd1));
		send_cmd(make_cmd(deq_pkg::FUNC_INSERT, '0, 4'd2, 48'd100, 32'd2));
		send_cmd(make_cmd(deq_pkg::FUNC_INSERT, '0, 4'd1, 48'd100, 32'd3));
		send_cmd(make_cmd(deq_pkg::FUNC_TICK, 48'd99, '0, '0, '0));
		send_cmd(make_cmd(deq_pkg::FUNC_TICK, 48'd100, '0, '0, '0));
		send_cmd(make_cmd(deq_pkg::FUNC_CANCEL, '0, 4'd7, '0, '0));
		send_cmd(make_cmd(deq_pkg::FUNC_CANCEL, '0, 4'd15, '0, '0));
		send_cmd(make_cmd(deq_pkg::FUNC_INSERT, '0, 4'd3, '1, 32'hA5A5_5A5A));
		send_cmd(make_cmd(deq_pkg::FUNC_TICK, '1, '0, '0, '0));

		// owner limit at one and at zero
		write_limit(9'd1);
		send_cmd(make_cmd(deq_pkg::FUNC_INSERT, '0, 4'd3, 48'd500, 32'd10));
		send_cmd(make_cmd(deq_pkg::FUNC_INSERT, '0, 4'd3, 48'd400, 32'd11));
		send_cmd(make_cmd(deq_pkg::FUNC_INSERT, '0, 4'd4, 48'd400, 32'd12));
		send_cmd(make_cmd(deq_pkg::FUNC_TICK, '1, '0, '0, '0));
		write_limit(9'd0);
		send_cmd(make_cmd(deq_pkg::FUNC_INSERT, '0, 4'd5, 48'd10, 32'd13));
		send_cmd(make_cmd(deq_pkg::FUNC_TICK, '1, '0, '0, '0));

		// fill the pool with one owner, overflow it, then cancel everything at once
		write_limit(9'd511);
		for (int i = 0; i < 33; i++)
			send_cmd(make_cmd(deq_pkg::FUNC_INSERT, wide_time(), 4'd6,
				now_us + $urandom_range(0, 9), $urandom));
		send_cmd(make_cmd(deq_pkg::FUNC_CANCEL, '0, 4'd6, '0, '0));
		// refill with many owners and drain in one tick
		for (int i = 0; i < 33; i++)
			send_cmd(make_cmd(deq_pkg::FUNC_INSERT, wide_time(), 4'($urandom),
				now_us + $urandom_range(0, 9), $urandom));
		send_cmd(make_cmd(deq_pkg::FUNC_TICK, now_us + 48'd9, '0, '0, '0));

		random_phase(20, 15);
		write_limit(9'd3);
		random_phase(20, 5);
		write_limit(9'd256);
		random_phase(20, 15);

		hold_cmd_idle();
		while (board.records_due.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("%0d items sent, %0d records checked, %0d mismatches",
			items_sent, board.records_seen, board.mismatches);
		$display("covered ticks, inserts, cancels, unused func, full pool, limits 0/1/3/256/511");
		if (board.mismatches == 0 && board.records_due.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule

>>> sim.f
rtl/deq_pkg.sv
rtl/deq_if.sv
rtl/deq_front.sv
rtl/deq_back.sv
rtl/deadline_event_queue.sv
tb/tb_deadline_event_queue.sv
